// ===== sv/pfd_pkg.sv =====
// Shared types and constants for the preamble/length frame deframer.
// Holds the register file struct, the result struct and the sync byte selector.
// No dependencies.
`timescale 1ns / 1ps

package pfd_pkg;

  // Bytes between the length field and the payload: one RSSI byte and four timestamp bytes.
  localparam int HEADER_BYTES = 5;
  localparam logic [16:0] HEADER_LEN = 17'(HEADER_BYTES);

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_WORD       = 2'd0;
  localparam logic [1:0] REG_UPLINK_LENGTH   = 2'd1;
  localparam logic [1:0] REG_DOWNLINK_LENGTH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] SYNC_WORD_RESET       = 32'h0AB0_CDE0;
  localparam logic [15:0] UPLINK_LENGTH_RESET   = 16'd552;
  localparam logic [15:0] DOWNLINK_LENGTH_RESET = 16'd48;

  // Length class codes.
  localparam logic [1:0] CLS_UPLINK     = 2'd0;
  localparam logic [1:0] CLS_DOWNLINK   = 2'd1;
  localparam logic [1:0] CLS_UNEXPECTED = 2'd2;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [15:0] uplink_length;
    logic [15:0] downlink_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic [15:0]       byte_index;
    logic signed [7:0] signal_strength;
    logic [31:0]       frame_timestamp;
    logic [1:0]        length_class;
    logic              last;
  } result_t;

  // Sync byte expected at match position pos; position zero is the top octet.
  function automatic logic [7:0] sync_byte(input logic [31:0] word, input logic [1:0] pos);
    logic [7:0] sel;
    unique case (pos)
      2'd0: sel = word[31:24];
      2'd1: sel = word[23:16];
      2'd2: sel = word[15:8];
      default: sel = word[7:0];
    endcase
    return sel;
  endfunction

endpackage

// ===== sv/pfd_cfg.sv =====
// Configuration register file of the frame deframer.
// Depends on pfd_pkg for the register struct, indexes and reset values.
`timescale 1ns / 1ps

module pfd_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output pfd_pkg::cfg_t regs
);
  import pfd_pkg::*;

  // Writes are always taken; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_word       <= SYNC_WORD_RESET;
      regs.uplink_length   <= UPLINK_LENGTH_RESET;
      regs.downlink_length <= DOWNLINK_LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_WORD:       regs.sync_word       <= cfg_data;
        REG_UPLINK_LENGTH:   regs.uplink_length   <= cfg_data[15:0];
        REG_DOWNLINK_LENGTH: regs.downlink_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/pfd_parser.sv =====
// Frame parser of the deframer: sync hunt, length field, header and payload tagging.
// Depends on pfd_pkg for the register and result structs and constants.
`timescale 1ns / 1ps

module pfd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic [7:0]      rx_byte,
  input  pfd_pkg::cfg_t   regs,
  output logic            res_valid,
  output pfd_pkg::result_t res
);
  import pfd_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_LEN_HI = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [1:0]  sync_matched, sync_matched_next;
  logic [15:0] payload_length, payload_length_next;
  logic [16:0] frame_length, frame_length_next;
  logic [16:0] bytes_taken, bytes_taken_next;
  logic [7:0]  rssi_held, rssi_held_next;
  logic [31:0] timestamp_held, timestamp_held_next;

  logic [16:0] bytes_plus;
  logic [16:0] payload_pos;
  logic        done;
  logic        is_payload;
  logic [1:0]  ts_slot;

  assign bytes_plus  = bytes_taken + 17'd1;
  assign payload_pos = bytes_taken - HEADER_LEN;
  assign done        = (bytes_plus >= frame_length);
  assign is_payload  = (bytes_taken >= HEADER_LEN);
  assign ts_slot     = bytes_taken[1:0] - 2'd1;

  always_comb begin
    phase_next          = phase;
    sync_matched_next   = sync_matched;
    payload_length_next = payload_length;
    frame_length_next   = frame_length;
    bytes_taken_next    = bytes_taken;
    rssi_held_next      = rssi_held;
    timestamp_held_next = timestamp_held;
    res_valid           = 1'b0;

    res.payload_byte    = rx_byte;
    res.byte_index      = payload_pos[15:0];
    res.signal_strength = rssi_held;
    res.frame_timestamp = timestamp_held;
    res.last            = done;
    priority if (payload_length == regs.uplink_length) begin
      res.length_class = CLS_UPLINK;
    end else if (payload_length == regs.downlink_length) begin
      res.length_class = CLS_DOWNLINK;
    end else begin
      res.length_class = CLS_UNEXPECTED;
    end

    if (in_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == sync_byte(regs.sync_word, sync_matched)) begin
            if (sync_matched == 2'd3) begin
              sync_matched_next = 2'd0;
              phase_next        = PH_LEN_LO;
            end else begin
              sync_matched_next = sync_matched + 2'd1;
            end
          end else if (sync_matched != 2'd0) begin
            // Restart and test the same byte as a possible first sync byte.
            sync_matched_next = (rx_byte == sync_byte(regs.sync_word, 2'd0)) ? 2'd1 : 2'd0;
          end
        end
        PH_LEN_LO: begin
          payload_length_next[7:0] = rx_byte;
          phase_next               = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          payload_length_next[15:8] = rx_byte;
          frame_length_next = {1'b0, rx_byte, payload_length[7:0]} + HEADER_LEN;
          bytes_taken_next  = 17'd0;
          phase_next        = PH_BODY;
        end
        default: begin
          if (bytes_taken == 17'd0) begin
            rssi_held_next = rx_byte;
          end else if (!is_payload) begin
            unique case (ts_slot)
              2'd0: timestamp_held_next[7:0]   = rx_byte;
              2'd1: timestamp_held_next[15:8]  = rx_byte;
              2'd2: timestamp_held_next[23:16] = rx_byte;
              default: timestamp_held_next[31:24] = rx_byte;
            endcase
          end else begin
            res_valid = 1'b1;
          end
          bytes_taken_next = bytes_plus;
          if (done) begin
            phase_next        = PH_HUNT;
            sync_matched_next = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_matched   <= 2'd0;
      payload_length <= 16'd0;
      frame_length   <= 17'd0;
      bytes_taken    <= 17'd0;
      rssi_held      <= 8'd0;
      timestamp_held <= 32'd0;
    end else begin
      phase          <= phase_next;
      sync_matched   <= sync_matched_next;
      payload_length <= payload_length_next;
      frame_length   <= frame_length_next;
      bytes_taken    <= bytes_taken_next;
      rssi_held      <= rssi_held_next;
      timestamp_held <= timestamp_held_next;
    end
  end

`ifndef SYNTHESIS
  a_sync_idle_outside_hunt: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HUNT) |-> (sync_matched == 2'd0))
    else $error("sync match count nonzero outside the sync hunt");

  a_body_within_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_taken < frame_length))
    else $error("byte count ran past the frame length");

  a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (phase == PH_HUNT))
    else $error("parser did not return to the sync hunt after the last byte");

  a_result_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (in_fire && phase == PH_BODY && frame_length > HEADER_LEN))
    else $error("result produced outside a nonempty payload");
`endif

endmodule

// ===== sv/pfd_out.sv =====
// Output register of the frame deframer: holds one result until the receiver takes it.
// Depends on pfd_pkg for the result struct.
`timescale 1ns / 1ps

module pfd_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             res_valid,
  input  pfd_pkg::result_t res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output pfd_pkg::result_t held
);
  import pfd_pkg::*;

  // The slot is free when it is empty or being drained in this cycle.
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      held <= res;
    end
  end

endmodule

// ===== sv/preamble_length_frame_deframer.sv =====
// Top level of the preamble/length frame deframer.
// Depends on pfd_pkg, pfd_cfg, pfd_parser and pfd_out.
`timescale 1ns / 1ps

// The block takes one received byte per transfer on the input channel
// (in_valid, in_ready, rx_byte). It hunts for the four-byte sync word, reads a
// 16-bit payload length low byte first, then an RSSI byte and a four-byte
// little-endian timestamp. Each payload byte leaves as one transfer on the
// output channel, tagged with its index, the RSSI, the timestamp, a length
// class and a last mark. Header bytes and frames of zero length give no output.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// accepted; an index past the three registers is dropped.
// A byte is handled in the cycle it is accepted and its result appears in the
// output register on the next cycle; the block takes one byte per cycle while
// the receiver does not stall, set by the single output register.
// When the receiver stalls, the held result stays in place and in_ready falls
// until that result is taken; it is high again in the same cycle as out_ready.
// Reset is synchronous: the parser returns to the sync hunt, the output empties
// and the registers take their default values.
module preamble_length_frame_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        payload_byte,
  output logic [15:0]       byte_index,
  output logic signed [7:0] signal_strength,
  output logic [31:0]       frame_timestamp,
  output logic [1:0]        length_class,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import pfd_pkg::*;

  cfg_t    regs;
  result_t res;
  result_t held;
  logic    res_valid;
  logic    space;
  logic    in_fire;

  assign in_ready = space;
  assign in_fire  = in_valid && space;

  pfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  pfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  pfd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign payload_byte    = held.payload_byte;
  assign byte_index      = held.byte_index;
  assign signal_strength = held.signal_strength;
  assign frame_timestamp = held.frame_timestamp;
  assign length_class    = held.length_class;
  assign last            = held.last;

endmodule
